FILE: rtl/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg: shared types and constants for the complex arithmetic unit
// Fixed-point format, operation codes and the widths of the root and
// divide pipelines.
// ---------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_W = 32;                 // word width
   localparam int FRAC_W = 28;                 // fractional bits
   localparam int ACT_W  = 3;

   localparam int RAD_W  = 2 * DATA_W;         // root radicand
   localparam int ROOT_W = DATA_W;             // root result, one bit per stage
   localparam int REM_W  = ROOT_W + 2;         // root partial remainder
   localparam int NUM_W  = DATA_W + FRAC_W - 1; // dividend, one quotient bit per stage
   localparam int DEN_W  = DATA_W;             // divisor

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic [ACT_W-1:0]         act_type;
   typedef logic [RAD_W-1:0]         rad_type;
   typedef logic [ROOT_W-1:0]        root_type;
   typedef logic [NUM_W-1:0]         num_type;
   typedef logic [DEN_W-1:0]         den_type;

   localparam act_type ACT_ADD  = 3'd0;
   localparam act_type ACT_SUB  = 3'd1;
   localparam act_type ACT_MUL  = 3'd2;
   localparam act_type ACT_NEG  = 3'd3;
   localparam act_type ACT_MOD  = 3'd4;
   localparam act_type ACT_SQRT = 3'd5;

endpackage

FILE: rtl/cau_isqrt.sv
// ---------------------------------------------------------------------------
// cau_isqrt: pipelined integer square root
// Floor of the square root of an unsigned radicand, one result bit per
// register stage, restoring digit-by-digit method.
// ---------------------------------------------------------------------------
module cau_isqrt (
   input  logic              clock,
   input  cau_pkg::rad_type  in_rad,
   output cau_pkg::root_type out_root
);
   import cau_pkg::*;

   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   logic [RAD_W-1:0]  rad_cur  [ROOT_W];
   logic [REM_W-1:0]  rem_cur  [ROOT_W];
   logic [ROOT_W-1:0] root_cur [ROOT_W];
   logic [REM_W+1:0]  rem_cat  [ROOT_W];
   logic [REM_W+1:0]  trial    [ROOT_W];
   logic              take     [ROOT_W];
   logic [REM_W-1:0]  rem_in   [ROOT_W];
   logic [ROOT_W-1:0] root_in  [ROOT_W];

   always_comb begin
      rad_cur[0]  = in_rad;
      rem_cur[0]  = '0;
      root_cur[0] = '0;
      for (int k = 1; k < ROOT_W; k++) begin
         rad_cur[k]  = rad_ff[k-1];
         rem_cur[k]  = rem_ff[k-1];
         root_cur[k] = root_ff[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         // bring down the next two radicand bits, try 4*root+1
         rem_cat[k] = {rem_cur[k], rad_cur[k][RAD_W-1 -: 2]};
         trial[k]   = {2'b00, root_cur[k], 2'b01};
         take[k]    = rem_cat[k] >= trial[k];
         rem_in[k]  = take[k] ? REM_W'(rem_cat[k] - trial[k]) : rem_cat[k][REM_W-1:0];
         root_in[k] = {root_cur[k][ROOT_W-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_W; k++) begin
         rad_ff[k]  <= rad_cur[k] << 2;
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_root = root_ff[ROOT_W-1];

endmodule

FILE: rtl/cau_div.sv
// ---------------------------------------------------------------------------
// cau_div: pipelined unsigned divider
// Restoring division, one quotient bit per register stage. Quotient bits
// shift into the dividend register as its bits are consumed.
// ---------------------------------------------------------------------------
module cau_div (
   input  logic             clock,
   input  cau_pkg::num_type in_num,
   input  cau_pkg::den_type in_den,
   output cau_pkg::num_type out_quo
);
   import cau_pkg::*;

   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   logic [NUM_W-1:0] nq_cur  [NUM_W];
   logic [DEN_W-1:0] rem_cur [NUM_W];
   logic [DEN_W-1:0] den_cur [NUM_W];
   logic [DEN_W:0]   rem_cat [NUM_W];
   logic             take    [NUM_W];
   logic [DEN_W-1:0] rem_in  [NUM_W];
   logic [NUM_W-1:0] nq_in   [NUM_W];

   always_comb begin
      nq_cur[0]  = in_num;
      rem_cur[0] = '0;
      den_cur[0] = in_den;
      for (int k = 1; k < NUM_W; k++) begin
         nq_cur[k]  = nq_ff[k-1];
         rem_cur[k] = rem_ff[k-1];
         den_cur[k] = den_ff[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_W; k++) begin
         rem_cat[k] = {rem_cur[k], nq_cur[k][NUM_W-1]};
         take[k]    = rem_cat[k] >= {1'b0, den_cur[k]};
         rem_in[k]  = take[k] ? DEN_W'(rem_cat[k] - {1'b0, den_cur[k]})
                              : rem_cat[k][DEN_W-1:0];
         nq_in[k]   = {nq_cur[k][NUM_W-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_W; k++) begin
         nq_ff[k]  <= nq_in[k];
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_cur[k];
      end
   end

   assign out_quo = nq_ff[NUM_W-1];

endmodule

FILE: rtl/complex_arith_unit.sv
// ---------------------------------------------------------------------------
// complex_arith_unit: pipelined complex ALU with square root
// Add, subtract, multiply, negate, modulus and principal square root of
// complex operands in signed Q4.28, saturating with an overflow flag.
//
//   channel   ports                        handshake
//   -------   --------------------------   -----------------------------
//   request   req_action, req_a_*, req_b_*  start high while busy low
//   result    rsp_r_re, rsp_r_im,          rsp_strobe, one cycle per beat
//             rsp_overflow
//
// One beat accepted per cycle. Each request passes through 3 front stages,
// two 32-stage root pipelines with a stage between them, a 59-stage divider
// and one output register.
// Reset is synchronous and clears all valid bits; busy is set during reset
// and cleared by the first clock edge with reset low. The result side cannot
// stall, so the pipeline advances every cycle.
// ---------------------------------------------------------------------------
module complex_arith_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cau_pkg::act_type  req_action,
   input  cau_pkg::word_type req_a_re,
   input  cau_pkg::word_type req_a_im,
   input  cau_pkg::word_type req_b_re,
   input  cau_pkg::word_type req_b_im,
   output logic              rsp_strobe,
   output cau_pkg::word_type rsp_r_re,
   output cau_pkg::word_type rsp_r_im,
   output logic              rsp_overflow
);
   import cau_pkg::*;

   localparam int SQ_LAT   = ROOT_W;
   localparam int DIV_LAT  = NUM_W;
   localparam int PIPE_LAT = 3 + SQ_LAT + 1 + SQ_LAT + DIV_LAT + 1;
   localparam int WIDE_W   = 2 * DATA_W + 1;
   localparam int S_W      = DATA_W + 2;
   localparam int IDX_A    = 2 + SQ_LAT;       // first root leaves its pipe
   localparam int IDX_B    = 3 + 2 * SQ_LAT;   // second root leaves its pipe

   localparam word_type W_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam word_type W_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MAX =
      {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = ~WIDE_MAX;

   typedef struct packed {
      act_type  act;
      word_type a_re;
      word_type a_im;
      word_type res_re;
      word_type res_im;
      logic     ovf;
   } side_type;

   function automatic logic sat_hit(input logic signed [WIDE_W-1:0] v);
      return (v > WIDE_MAX) || (v < WIDE_MIN);
   endfunction

   function automatic word_type sat_val(input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_MAX) return W_MAX;
      if (v < WIDE_MIN) return W_MIN;
      return v[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] mag_of(input word_type v);
      return v[DATA_W-1] ? DATA_W'(-v) : v;
   endfunction

   logic busy_ff;
   logic take_beat;
   logic [PIPE_LAT-1:0] vld_ff;

   assign take_beat = start && !busy_ff;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[PIPE_LAT-2:0], take_beat};
      end
   end

   // ---- stage 0: capture; modulus and square root square a into the multipliers
   act_type  act0_ff;
   word_type are0_ff, aim0_ff, bre0_ff, bim0_ff;
   logic     sq_sel;

   assign sq_sel = (req_action == ACT_MOD) || (req_action == ACT_SQRT);

   always_ff @(posedge clock) begin
      act0_ff <= req_action;
      are0_ff <= req_a_re;
      aim0_ff <= req_a_im;
      bre0_ff <= sq_sel ? req_a_re : req_b_re;
      bim0_ff <= sq_sel ? req_a_im : req_b_im;
   end

   // ---- stage 1: products and the simple ops
   logic signed [2*DATA_W-1:0] prr1_ff, pii1_ff, pri1_ff, pir1_ff;
   act_type  act1_ff;
   word_type are1_ff, aim1_ff, rre1_ff, rim1_ff;
   logic     ovf1_ff;
   logic signed [DATA_W:0] ex_are0, ex_aim0, ex_bre0, ex_bim0, s_re, s_im;
   word_type rre1_in, rim1_in;
   logic     ovf1_in;

   assign ex_are0 = {are0_ff[DATA_W-1], are0_ff};
   assign ex_aim0 = {aim0_ff[DATA_W-1], aim0_ff};
   assign ex_bre0 = {bre0_ff[DATA_W-1], bre0_ff};
   assign ex_bim0 = {bim0_ff[DATA_W-1], bim0_ff};

   always_comb begin
      s_re    = '0;
      s_im    = '0;
      rre1_in = '0;
      rim1_in = '0;
      ovf1_in = 1'b0;
      case (act0_ff)
         ACT_ADD: begin
            s_re = ex_are0 + ex_bre0;
            s_im = ex_aim0 + ex_bim0;
         end
         ACT_SUB: begin
            s_re = ex_are0 - ex_bre0;
            s_im = ex_aim0 - ex_bim0;
         end
         ACT_NEG: begin
            s_re = '0 - ex_are0;
            s_im = '0 - ex_aim0;
         end
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase
      rre1_in = sat_val(WIDE_W'(s_re));
      rim1_in = sat_val(WIDE_W'(s_im));
      ovf1_in = sat_hit(WIDE_W'(s_re)) || sat_hit(WIDE_W'(s_im));
   end

   always_ff @(posedge clock) begin
      prr1_ff <= are0_ff * bre0_ff;
      pii1_ff <= aim0_ff * bim0_ff;
      pri1_ff <= are0_ff * bim0_ff;
      pir1_ff <= aim0_ff * bre0_ff;
      act1_ff <= act0_ff;
      are1_ff <= are0_ff;
      aim1_ff <= aim0_ff;
      rre1_ff <= rre1_in;
      rim1_ff <= rim1_in;
      ovf1_ff <= ovf1_in;
   end

   // ---- stage 2: product combine, first radicand
   side_type side2_ff, side2_in;
   rad_type  rad1_ff, rad1_in;
   logic signed [WIDE_W-1:0] m_re, m_im;

   assign m_re = (WIDE_W'(prr1_ff) - WIDE_W'(pii1_ff)) >>> FRAC_W;
   assign m_im = (WIDE_W'(pri1_ff) + WIDE_W'(pir1_ff)) >>> FRAC_W;

   always_comb begin
      side2_in.act  = act1_ff;
      side2_in.a_re = are1_ff;
      side2_in.a_im = aim1_ff;
      if (act1_ff == ACT_MUL) begin
         side2_in.res_re = sat_val(m_re);
         side2_in.res_im = sat_val(m_im);
         side2_in.ovf    = sat_hit(m_re) || sat_hit(m_im);
      end else begin
         side2_in.res_re = rre1_ff;
         side2_in.res_im = rim1_ff;
         side2_in.ovf    = ovf1_ff;
      end
      if ((act1_ff == ACT_SQRT) && (aim1_ff == '0)) begin
         rad1_in = RAD_W'({mag_of(are1_ff), {FRAC_W{1'b0}}});
      end else begin
         rad1_in = $unsigned(prr1_ff) + $unsigned(pii1_ff);
      end
   end

   always_ff @(posedge clock) begin
      side2_ff <= side2_in;
      rad1_ff  <= rad1_in;
   end

   // ---- first root: modulus, or the root of a real operand
   root_type root1;
   side_type sd_a_ff [SQ_LAT];

   cau_isqrt u_sqrt_mod (
      .clock    (clock),
      .in_rad   (rad1_ff),
      .out_root (root1)
   );

   always_ff @(posedge clock) begin
      sd_a_ff[0] <= side2_ff;
      for (int k = 1; k < SQ_LAT; k++) begin
         sd_a_ff[k] <= sd_a_ff[k-1];
      end
   end

   side_type sa, side3_ff, side3_in;
   rad_type  rad2_ff, rad2_in;
   logic [S_W-1:0] sum_m;

   assign sa    = sd_a_ff[SQ_LAT-1];
   assign sum_m = S_W'(sa.a_re) + S_W'(root1);
   assign rad2_in = RAD_W'({sum_m[S_W-2:0], {(FRAC_W-1){1'b0}}});

   always_comb begin
      side3_in = sa;
      if (sa.act == ACT_MOD) begin
         side3_in.res_re = root1[ROOT_W-1] ? W_MAX : root1;
         side3_in.res_im = '0;
         side3_in.ovf    = root1[ROOT_W-1];
      end else if ((sa.act == ACT_SQRT) && (sa.a_im == '0)) begin
         side3_in.ovf = 1'b0;
         if (sa.a_re[DATA_W-1]) begin
            side3_in.res_re = '0;
            side3_in.res_im = root1;
         end else begin
            side3_in.res_re = root1;
            side3_in.res_im = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      side3_ff <= side3_in;
      rad2_ff  <= rad2_in;
   end

   // ---- second root: x = sqrt((re + |z|) / 2)
   root_type root2;
   side_type sd_b_ff [SQ_LAT];

   cau_isqrt u_sqrt_half (
      .clock    (clock),
      .in_rad   (rad2_ff),
      .out_root (root2)
   );

   always_ff @(posedge clock) begin
      sd_b_ff[0] <= side3_ff;
      for (int k = 1; k < SQ_LAT; k++) begin
         sd_b_ff[k] <= sd_b_ff[k-1];
      end
   end

   // ---- divide: y = im / (2x)
   side_type sb, side_c_in;
   logic     cplx_b;
   num_type  quo;
   side_type sd_c_ff [DIV_LAT];

   assign sb     = sd_b_ff[SQ_LAT-1];
   assign cplx_b = (sb.act == ACT_SQRT) && (sb.a_im != '0);

   always_comb begin
      side_c_in = sb;
      if (cplx_b) begin
         side_c_in.res_re = root2;
      end
   end

   cau_div u_div (
      .clock   (clock),
      .in_num  ({mag_of(sb.a_im), {(FRAC_W-1){1'b0}}}),
      .in_den  (root2),
      .out_quo (quo)
   );

   always_ff @(posedge clock) begin
      sd_c_ff[0] <= side_c_in;
      for (int k = 1; k < DIV_LAT; k++) begin
         sd_c_ff[k] <= sd_c_ff[k-1];
      end
   end

   // ---- final select and saturate
   side_type sc;
   logic signed [WIDE_W-1:0] q_wide, y_val;
   word_type re_in, im_in;
   logic     ovf_in;
   word_type re_ff, im_ff;
   logic     ovf_ff;

   assign sc     = sd_c_ff[DIV_LAT-1];
   assign q_wide = WIDE_W'(quo);
   assign y_val  = sc.a_im[DATA_W-1] ? -q_wide : q_wide;

   always_comb begin
      re_in  = sc.res_re;
      im_in  = sc.res_im;
      ovf_in = sc.ovf;
      if ((sc.act == ACT_SQRT) && (sc.a_im != '0)) begin
         if (sc.res_re == '0) begin
            // zero divisor: pin y toward the sign of im
            im_in  = sc.a_im[DATA_W-1] ? W_MIN : W_MAX;
            ovf_in = 1'b1;
         end else begin
            im_in  = sat_val(y_val);
            ovf_in = sat_hit(y_val);
         end
      end
   end

   always_ff @(posedge clock) begin
      re_ff  <= re_in;
      im_ff  <= im_in;
      ovf_ff <= ovf_in;
   end

   assign rsp_strobe   = vld_ff[PIPE_LAT-1];
   assign rsp_r_re     = re_ff;
   assign rsp_r_im     = im_ff;
   assign rsp_overflow = ovf_ff;

   // ---- checks
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      take_beat |-> ##PIPE_LAT rsp_strobe)
      else $error("result beat missing at fixed latency");

   a_half_sum_nonneg: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[IDX_A] && (sa.act == ACT_SQRT) && (sa.a_im != '0)) |-> !sum_m[S_W-1])
      else $error("re + |z| went negative");

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[IDX_B] && cplx_b) |-> !root2[ROOT_W-1])
      else $error("half-angle root exceeds word range");

endmodule

FILE: sim/cau_checker.sv
// ---------------------------------------------------------------------------
// cau_checker: result predictor and scoreboard for the complex arithmetic unit
// Watches accepted requests, computes the expected complex result in wide
// integer arithmetic, and compares each result beat with the oldest one.
// ---------------------------------------------------------------------------
module cau_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  cau_pkg::act_type  req_action,
   input  cau_pkg::word_type req_a_re,
   input  cau_pkg::word_type req_a_im,
   input  cau_pkg::word_type req_b_re,
   input  cau_pkg::word_type req_b_im,
   input  logic              rsp_strobe,
   input  cau_pkg::word_type rsp_r_re,
   input  cau_pkg::word_type rsp_r_im,
   input  logic              rsp_overflow,
   output int                fail_count,
   output int                pending
);
   import cau_pkg::*;

   typedef struct packed {
      word_type re;
      word_type im;
      logic     ovf;
   } cplx_result_type;

   localparam logic signed [127:0] WORD_MAX = (128'sd1 <<< (DATA_W - 1)) - 1;
   localparam logic signed [127:0] WORD_MIN = -(128'sd1 <<< (DATA_W - 1));

   cplx_result_type result_queue[$];

   function automatic word_type clamp(input logic signed [127:0] v, inout logic ovf);
      if (v > WORD_MAX) begin
         ovf = 1'b1;
         return WORD_MAX[DATA_W-1:0];
      end
      if (v < WORD_MIN) begin
         ovf = 1'b1;
         return WORD_MIN[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [127:0] v);
      logic [127:0] root;
      logic [127:0] bitv;
      logic [127:0] trial;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         bitv  = 128'd1 << (2 * i);
         trial = root + bitv;
         if (v >= trial) begin
            v    = v - trial;
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic cplx_result_type predict_cplx(input act_type act, input word_type ar,
         input word_type ai, input word_type br, input word_type bi);
      cplx_result_type r;
      logic signed [127:0] p;
      logic signed [127:0] q;
      logic [127:0] msq;
      logic [63:0]  m;
      logic [63:0]  x;
      logic [127:0] quo;
      logic [127:0] s;
      logic ovf;
      ovf = 1'b0;
      r = '0;
      case (act)
         ACT_ADD: begin
            r.re = clamp(128'(ar) + 128'(br), ovf);
            r.im = clamp(128'(ai) + 128'(bi), ovf);
         end
         ACT_SUB: begin
            r.re = clamp(128'(ar) - 128'(br), ovf);
            r.im = clamp(128'(ai) - 128'(bi), ovf);
         end
         ACT_MUL: begin
            p = 128'(ar) * 128'(br) - 128'(ai) * 128'(bi);
            q = 128'(ar) * 128'(bi) + 128'(ai) * 128'(br);
            r.re = clamp(p >>> FRAC_W, ovf);
            r.im = clamp(q >>> FRAC_W, ovf);
         end
         ACT_NEG: begin
            r.re = clamp(-128'(ar), ovf);
            r.im = clamp(-128'(ai), ovf);
         end
         ACT_MOD: begin
            msq  = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
            r.re = clamp($signed({64'd0, int_sqrt(msq)}), ovf);
         end
         ACT_SQRT: begin
            if (ai != 0) begin
               msq = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
               m   = int_sqrt(msq);
               s   = 128'(ar) + {64'd0, m};
               x   = int_sqrt(s << (FRAC_W - 1));
               r.re = clamp($signed({64'd0, x}), ovf);
               if (x == 0) begin
                  ovf  = 1'b1;
                  r.im = ai[DATA_W-1] ? WORD_MIN[DATA_W-1:0] : WORD_MAX[DATA_W-1:0];
               end else begin
                  quo = ({64'd0, 64'(ai[DATA_W-1] ? -128'(ai) : 128'(ai))}
                         << (FRAC_W - 1)) / {64'd0, x};
                  r.im = clamp(ai[DATA_W-1] ? -$signed(quo) : $signed(quo), ovf);
               end
            end else if (!ar[DATA_W-1]) begin
               r.re = clamp($signed({64'd0, int_sqrt(128'(ar) << FRAC_W)}), ovf);
            end else begin
               r.im = clamp($signed({64'd0, int_sqrt((-128'(ar)) << FRAC_W)}), ovf);
            end
         end
         default: ;
      endcase
      r.ovf = ovf;
      return r;
   endfunction

   assign pending = result_queue.size();

   always @(posedge clock) begin
      cplx_result_type want;
      if (reset) begin
         result_queue.delete();
         fail_count <= 0;
      end else begin
         if (start && !busy)
            result_queue.push_back(predict_cplx(req_action, req_a_re, req_a_im,
                                                req_b_re, req_b_im));
         if (rsp_strobe) begin
            if (result_queue.size() == 0) begin
               $error("result beat with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = result_queue.pop_front();
               if (rsp_r_re !== want.re || rsp_r_im !== want.im
                   || rsp_overflow !== want.ovf) begin
                  if (rsp_r_re !== want.re)
                     $error("r_re expected %0d got %0d", want.re, rsp_r_re);
                  if (rsp_r_im !== want.im)
                     $error("r_im expected %0d got %0d", want.im, rsp_r_im);
                  if (rsp_overflow !== want.ovf)
                     $error("overflow expected %0b got %0b", want.ovf, rsp_overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the complex arithmetic unit
// Drives directed corner operands and a full drain, then random beats with random gaps
// (none for part of the run), a full drain midway and one at the end; the checker predicts and scores every result.
// ---------------------------------------------------------------------------
module testbench;
   import cau_pkg::*;

   localparam int LATENCY   = 128;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 700;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   act_type  req_action = ACT_ADD;
   word_type req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic     rsp_strobe;
   word_type rsp_r_re, rsp_r_im;
   logic     rsp_overflow;
   int       fail_count;
   int       pending;
   int       idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   complex_arith_unit DUT (.*);

   cau_checker u_checker (.*);

   // count cycles with no accepted beat on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return '0;
         3: return word_type'($urandom_range(0, 1) ? 1 : -1);
         4: return $urandom_range(0, 32'h3fff_ffff) - 32'h2000_0000;
         5: return $urandom_range(0, 32'h07ff_ffff) - 32'h0400_0000;
         default: return $urandom;
      endcase
   endfunction

   // present one beat and hold it until accepted
   task automatic send_op(input act_type act, input word_type ar, input word_type ai,
         input word_type br, input word_type bi, input bit hold_gaps);
      if (hold_gaps) begin
         while ($urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start      <= 1'b1;
      req_action <= act;
      req_a_re   <= ar;
      req_a_im   <= ai;
      req_b_re   <= br;
      req_b_im   <= bi;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      act_type act;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      send_op(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 0);
      send_op(ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 0);
      send_op(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_op(ACT_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_op(ACT_MUL, 32'h1000_0000, 32'h0000_0000, 32'hf000_0000, 32'h1000_0000, 0);
      send_op(ACT_NEG, 32'h8000_0000, 32'h8000_0000, '0, '0, 0);
      send_op(ACT_NEG, 32'h7fff_ffff, 32'h0000_0001, '1, '1, 0);
      send_op(ACT_MOD, 32'h8000_0000, 32'h8000_0000, '0, '0, 0);
      send_op(ACT_MOD, 32'h3000_0000, 32'h4000_0000, '0, '0, 0);
      send_op(ACT_SQRT, 32'h4000_0000, 32'h0000_0000, '1, '1, 0);
      send_op(ACT_SQRT, 32'hc000_0000, 32'h0000_0000, '0, '0, 0);
      send_op(ACT_SQRT, 32'h8000_0000, 32'h0000_0000, '0, '0, 0);
      send_op(ACT_SQRT, 32'h8000_0000, 32'h0000_0001, '0, '0, 0);
      send_op(ACT_SQRT, 32'h8000_0000, 32'hffff_ffff, '0, '0, 0);
      send_op(ACT_SQRT, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0, 0);
      send_op(ACT_SQRT, 32'hf000_0000, 32'h8000_0000, '0, '0, 0);
      send_op(ACT_SQRT, '0, '0, '0, '0, 0);
      send_op(act_type'(6), 32'h1234_5678, 32'h8765_4321, '1, '1, 0);
      send_op(act_type'(7), 32'h7fff_ffff, 32'h8000_0000, '1, '1, 0);
      // full drain before the random part
      drain();
      for (int i = 0; i < N_RANDOM; i++) begin
         act = ($urandom_range(0, 19) == 0) ? act_type'($urandom_range(6, 7))
                                            : act_type'($urandom_range(0, 5));
         send_op(act, pick_word(), pick_word(), pick_word(), pick_word(),
                 !(i >= 200 && i < 350));
         if (i == 450) drain();
      end
      drain();
      repeat (LATENCY + 8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
